[rtl/vpa_pkg.sv]
// ----------------------------------------------------------------------------
// vpa_pkg: shared definitions for the variable partition allocator
// Table geometry, opcodes, status codes, controller states and the
// command/status types that join the controller and the datapath.
// ----------------------------------------------------------------------------
package vpa_pkg;

   // Table geometry
   localparam int TABLE_DEPTH   = 8;
   localparam int ADDR_WIDTH    = 16;
   localparam int IDX_WIDTH     = $clog2(TABLE_DEPTH);
   localparam int CNT_WIDTH     = $clog2(TABLE_DEPTH + 1);

   // Field widths of the channels
   localparam int OP_WIDTH      = 2;
   localparam int STATUS_WIDTH  = 2;
   localparam int OUT_CNT_WIDTH = 4;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_ADD       = 2'd0,
      OP_BEST_FIT  = 2'd1,
      OP_WORST_FIT = 2'd2,
      OP_FREE      = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK         = 2'd0,
      ST_NO_FIT     = 2'd1,
      ST_TABLE_FULL = 2'd2,
      ST_NOT_FOUND  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_FIT_SCAN,
      S_FIND_SCAN,
      S_FREE_NEXT,
      S_FREE_PREV,
      S_RESP
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_ADD,
      CMD_NO_FIT,
      CMD_FIT_STEP,
      CMD_ALLOC_FINISH,
      CMD_FIND_STEP,
      CMD_NOT_FOUND,
      CMD_FREE_MARK,
      CMD_MERGE_NEXT,
      CMD_MERGE_PREV
   } dp_cmd_type;

   // Datapath flags seen by the controller
   typedef struct packed {
      opcode_type opcode;
      logic       size_zero;
      logic       scan_end;
      logic       rd_hit;
      logic       rd_used;
   } dp_status_type;

endpackage

[rtl/vpa_req_if.sv]
// ----------------------------------------------------------------------------
// vpa_req_if: request channel
// Valid/ready channel that carries one allocator request transaction.
// ----------------------------------------------------------------------------
interface vpa_req_if;
   import vpa_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [OP_WIDTH-1:0]   opcode;
   logic [ADDR_WIDTH-1:0] addr;
   logic [ADDR_WIDTH-1:0] req_size;
   logic                  mark_used;

   modport source (output valid, output opcode, output addr, output req_size,
                   output mark_used, input ready);
   modport sink   (input valid, input opcode, input addr, input req_size,
                   input mark_used, output ready);
endinterface

[rtl/vpa_rsp_if.sv]
// ----------------------------------------------------------------------------
// vpa_rsp_if: response channel
// Valid/ready channel that carries one allocator response transaction.
// ----------------------------------------------------------------------------
interface vpa_rsp_if;
   import vpa_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [STATUS_WIDTH-1:0]  status;
   logic [ADDR_WIDTH-1:0]    block_start;
   logic [ADDR_WIDTH-1:0]    block_size;
   logic [OUT_CNT_WIDTH-1:0] free_count;
   logic [OUT_CNT_WIDTH-1:0] entry_total;

   modport source (output valid, output status, output block_start, output block_size,
                   output free_count, output entry_total, input ready);
   modport sink   (input valid, input status, input block_start, input block_size,
                   input free_count, input entry_total, output ready);
endinterface

[rtl/variable_partition_allocator_core.sv]
// Sequence: add goes from request accept through decode to the response; allocate
// runs the fit scan, one entry per cycle, then the finish step; free runs
// the address scan, the release and one merge step for each neighbor.
// Throughput: one transaction at a time; the next is taken as the response drains.
// Reset: synchronous; the table empties (entry and free counts zero), no
// clearing pass is needed.
// ----------------------------------------------------------------------------
// variable_partition_allocator_core: best-fit / worst-fit partition allocator
// Ordered partition table with add, best-fit and worst-fit allocate with
// split, and free with merge of touching free neighbors.
// ----------------------------------------------------------------------------
module variable_partition_allocator_core (
   input logic      clock,
   input logic      reset,
   vpa_req_if.sink   req_chan,
   vpa_rsp_if.source rsp_chan
);
   import vpa_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type sts;
   logic          ctrl_req_ready;
   logic          ctrl_rsp_valid;

   // Sequencer
   vpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ctrl_req_ready),
      .rsp_valid (ctrl_rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Table and arithmetic
   vpa_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_opcode      (req_chan.opcode),
      .req_addr        (req_chan.addr),
      .req_size        (req_chan.req_size),
      .req_mark_used   (req_chan.mark_used),
      .rsp_status      (rsp_chan.status),
      .rsp_block_start (rsp_chan.block_start),
      .rsp_block_size  (rsp_chan.block_size),
      .rsp_free_count  (rsp_chan.free_count),
      .rsp_entry_total (rsp_chan.entry_total)
   );

   assign req_chan.ready = ctrl_req_ready;
   assign rsp_chan.valid = ctrl_rsp_valid;

endmodule

[rtl/vpa_dp.sv]
// ----------------------------------------------------------------------------
// vpa_dp: allocator datapath
// Partition table, scan pointer, best candidate, merge arithmetic and the
// response registers. Executes one command from the controller per cycle.
// ----------------------------------------------------------------------------
module vpa_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  vpa_pkg::dp_cmd_type              cmd,
   output vpa_pkg::dp_status_type           sts,
   input  logic [vpa_pkg::OP_WIDTH-1:0]     req_opcode,
   input  logic [vpa_pkg::ADDR_WIDTH-1:0]   req_addr,
   input  logic [vpa_pkg::ADDR_WIDTH-1:0]   req_size,
   input  logic                             req_mark_used,
   output logic [vpa_pkg::STATUS_WIDTH-1:0] rsp_status,
   output logic [vpa_pkg::ADDR_WIDTH-1:0]   rsp_block_start,
   output logic [vpa_pkg::ADDR_WIDTH-1:0]   rsp_block_size,
   output logic [vpa_pkg::OUT_CNT_WIDTH-1:0] rsp_free_count,
   output logic [vpa_pkg::OUT_CNT_WIDTH-1:0] rsp_entry_total
);
   import vpa_pkg::*;

   // Partition table
   logic [ADDR_WIDTH-1:0] start_ff [TABLE_DEPTH];
   logic [ADDR_WIDTH-1:0] start_in [TABLE_DEPTH];
   logic [ADDR_WIDTH-1:0] size_ff  [TABLE_DEPTH];
   logic [ADDR_WIDTH-1:0] size_in  [TABLE_DEPTH];
   logic                  used_ff  [TABLE_DEPTH];
   logic                  used_in  [TABLE_DEPTH];

   // Control state
   logic [CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic [CNT_WIDTH-1:0]  free_ff, free_in;
   logic [CNT_WIDTH-1:0]  ptr_ff, ptr_in;
   logic                  found_ff, found_in;

   // Working payload
   opcode_type            op_ff, op_in;
   logic [ADDR_WIDTH-1:0] addr_ff, addr_in;
   logic [ADDR_WIDTH-1:0] size_req_ff, size_req_in;
   logic                  mark_ff, mark_in;
   logic [IDX_WIDTH-1:0]  pick_ff, pick_in;
   logic [ADDR_WIDTH-1:0] pick_size_ff, pick_size_in;
   logic [ADDR_WIDTH-1:0] pick_start_ff, pick_start_in;
   logic [IDX_WIDTH-1:0]  k_ff, k_in;
   logic [ADDR_WIDTH-1:0] cur_start_ff, cur_start_in;
   logic [ADDR_WIDTH-1:0] cur_size_ff, cur_size_in;
   status_type            status_ff, status_in;
   logic [ADDR_WIDTH-1:0] bstart_ff, bstart_in;
   logic [ADDR_WIDTH-1:0] bsize_ff, bsize_in;

   // Single read port at the scan pointer
   logic [IDX_WIDTH-1:0]  rd_idx;
   logic [ADDR_WIDTH-1:0] rd_start;
   logic [ADDR_WIDTH-1:0] rd_size;
   logic                  rd_used;
   logic [IDX_WIDTH-1:0]  cnt_idx;
   logic                  full;
   logic                  better;
   logic [ADDR_WIDTH:0]   pair_sum;
   logic [ADDR_WIDTH:0]   cur_end;
   logic [ADDR_WIDTH:0]   rd_end;
   logic                  next_ok;
   logic                  prev_ok;
   logic [CNT_WIDTH-1:0]  pick_next;
   logic [CNT_WIDTH-1:0]  k_wide;

   assign rd_idx   = ptr_ff[IDX_WIDTH-1:0];
   assign rd_start = start_ff[rd_idx];
   assign rd_size  = size_ff[rd_idx];
   assign rd_used  = used_ff[rd_idx];
   assign cnt_idx  = cnt_ff[IDX_WIDTH-1:0];
   assign full     = (cnt_ff == CNT_WIDTH'(TABLE_DEPTH));

   // Merge arithmetic: touching addresses and no carry out of the sum
   assign pair_sum = {1'b0, cur_size_ff} + {1'b0, rd_size};
   assign cur_end  = {1'b0, cur_start_ff} + {1'b0, cur_size_ff};
   assign rd_end   = {1'b0, rd_start} + {1'b0, rd_size};
   assign next_ok  = (ptr_ff < cnt_ff) && !rd_used && (cur_end == {1'b0, rd_start})
                     && !pair_sum[ADDR_WIDTH];
   assign prev_ok  = (k_ff != '0) && !rd_used && (rd_end == {1'b0, cur_start_ff})
                     && !pair_sum[ADDR_WIDTH];

   // Fit candidate compare, earliest entry wins ties
   assign better = !rd_used && (rd_size >= size_req_ff) &&
                   (!found_ff ||
                    ((op_ff == OP_BEST_FIT) && (rd_size < pick_size_ff)) ||
                    ((op_ff == OP_WORST_FIT) && (rd_size > pick_size_ff)));

   assign pick_next = CNT_WIDTH'(pick_ff) + CNT_WIDTH'(1);
   assign k_wide    = CNT_WIDTH'(k_ff);

   // Flags for the controller
   assign sts.opcode    = op_ff;
   assign sts.size_zero = (size_req_ff == '0);
   assign sts.scan_end  = (ptr_ff >= cnt_ff);
   assign sts.rd_hit    = (rd_start == addr_ff);
   assign sts.rd_used   = rd_used;

   // Execute the current command
   always_comb begin
      start_in      = start_ff;
      size_in       = size_ff;
      used_in       = used_ff;
      cnt_in        = cnt_ff;
      free_in       = free_ff;
      ptr_in        = ptr_ff;
      found_in      = found_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      size_req_in   = size_req_ff;
      mark_in       = mark_ff;
      pick_in       = pick_ff;
      pick_size_in  = pick_size_ff;
      pick_start_in = pick_start_ff;
      k_in          = k_ff;
      cur_start_in  = cur_start_ff;
      cur_size_in   = cur_size_ff;
      status_in     = status_ff;
      bstart_in     = bstart_ff;
      bsize_in      = bsize_ff;

      unique case (cmd)
         CMD_NONE: begin
         end
         CMD_LOAD: begin
            op_in       = opcode_type'(req_opcode);
            addr_in     = req_addr;
            size_req_in = req_size;
            mark_in     = req_mark_used;
            ptr_in      = '0;
            found_in    = 1'b0;
         end
         CMD_ADD: begin
            if (!full) begin
               start_in[cnt_idx] = addr_ff;
               size_in[cnt_idx]  = size_req_ff;
               used_in[cnt_idx]  = mark_ff;
               cnt_in            = cnt_ff + CNT_WIDTH'(1);
               free_in           = free_ff + CNT_WIDTH'(!mark_ff);
               status_in         = ST_OK;
               bstart_in         = addr_ff;
               bsize_in          = size_req_ff;
            end else begin
               status_in = ST_TABLE_FULL;
               bstart_in = '0;
               bsize_in  = '0;
            end
         end
         CMD_NO_FIT: begin
            status_in = ST_NO_FIT;
            bstart_in = '0;
            bsize_in  = '0;
         end
         CMD_FIT_STEP: begin
            if (better) begin
               found_in      = 1'b1;
               pick_in       = rd_idx;
               pick_size_in  = rd_size;
               pick_start_in = rd_start;
            end
            ptr_in = ptr_ff + CNT_WIDTH'(1);
         end
         CMD_ALLOC_FINISH: begin
            if (!found_ff) begin
               status_in = ST_NO_FIT;
               bstart_in = '0;
               bsize_in  = '0;
            end else if (pick_size_ff == size_req_ff) begin
               used_in[pick_ff] = 1'b1;
               free_in          = free_ff - CNT_WIDTH'(1);
               status_in        = ST_OK;
               bstart_in        = pick_start_ff;
               bsize_in         = size_req_ff;
            end else if (!full) begin
               // split: open a slot after the pick and place the free remainder there
               for (int j = 0; j < TABLE_DEPTH; j++) begin
                  if ((CNT_WIDTH'(j) > pick_next) && (CNT_WIDTH'(j) <= cnt_ff)) begin
                     start_in[j] = start_ff[(j == 0) ? 0 : j - 1];
                     size_in[j]  = size_ff[(j == 0) ? 0 : j - 1];
                     used_in[j]  = used_ff[(j == 0) ? 0 : j - 1];
                  end else if (CNT_WIDTH'(j) == pick_next) begin
                     start_in[j] = pick_start_ff + size_req_ff;
                     size_in[j]  = pick_size_ff - size_req_ff;
                     used_in[j]  = 1'b0;
                  end else if (CNT_WIDTH'(j) == CNT_WIDTH'(pick_ff)) begin
                     size_in[j]  = size_req_ff;
                     used_in[j]  = 1'b1;
                  end
               end
               cnt_in    = cnt_ff + CNT_WIDTH'(1);
               status_in = ST_OK;
               bstart_in = pick_start_ff;
               bsize_in  = size_req_ff;
            end else begin
               status_in = ST_TABLE_FULL;
               bstart_in = '0;
               bsize_in  = '0;
            end
         end
         CMD_FIND_STEP: begin
            ptr_in = ptr_ff + CNT_WIDTH'(1);
         end
         CMD_NOT_FOUND: begin
            status_in = ST_NOT_FOUND;
            bstart_in = '0;
            bsize_in  = '0;
         end
         CMD_FREE_MARK: begin
            used_in[rd_idx] = 1'b0;
            free_in         = free_ff + CNT_WIDTH'(1);
            k_in            = rd_idx;
            cur_start_in    = rd_start;
            cur_size_in     = rd_size;
            ptr_in          = ptr_ff + CNT_WIDTH'(1);
         end
         CMD_MERGE_NEXT: begin
            // absorb the following entry and close the gap it leaves
            if (next_ok) begin
               size_in[k_ff] = pair_sum[ADDR_WIDTH-1:0];
               cur_size_in   = pair_sum[ADDR_WIDTH-1:0];
               for (int j = 0; j < TABLE_DEPTH; j++) begin
                  if ((CNT_WIDTH'(j) >= ptr_ff) && (CNT_WIDTH'(j + 1) < cnt_ff)) begin
                     start_in[j] = start_ff[(j == TABLE_DEPTH - 1) ? j : j + 1];
                     size_in[j]  = size_ff[(j == TABLE_DEPTH - 1) ? j : j + 1];
                     used_in[j]  = used_ff[(j == TABLE_DEPTH - 1) ? j : j + 1];
                  end
               end
               cnt_in  = cnt_ff - CNT_WIDTH'(1);
               free_in = free_ff - CNT_WIDTH'(1);
            end
            ptr_in = k_wide - CNT_WIDTH'(1);
         end
         CMD_MERGE_PREV: begin
            // fold the released entry into the preceding one
            if (prev_ok) begin
               size_in[rd_idx] = pair_sum[ADDR_WIDTH-1:0];
               for (int j = 0; j < TABLE_DEPTH; j++) begin
                  if ((CNT_WIDTH'(j) >= k_wide) && (CNT_WIDTH'(j + 1) < cnt_ff)) begin
                     start_in[j] = start_ff[(j == TABLE_DEPTH - 1) ? j : j + 1];
                     size_in[j]  = size_ff[(j == TABLE_DEPTH - 1) ? j : j + 1];
                     used_in[j]  = used_ff[(j == TABLE_DEPTH - 1) ? j : j + 1];
                  end
               end
               cnt_in    = cnt_ff - CNT_WIDTH'(1);
               free_in   = free_ff - CNT_WIDTH'(1);
               bstart_in = rd_start;
               bsize_in  = pair_sum[ADDR_WIDTH-1:0];
            end else begin
               bstart_in = cur_start_ff;
               bsize_in  = cur_size_ff;
            end
            status_in = ST_OK;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         free_ff  <= '0;
         ptr_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         free_ff  <= free_in;
         ptr_ff   <= ptr_in;
         found_ff <= found_in;
      end
   end

   // Table and payload registers
   always_ff @(posedge clock) begin
      start_ff      <= start_in;
      size_ff       <= size_in;
      used_ff       <= used_in;
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      size_req_ff   <= size_req_in;
      mark_ff       <= mark_in;
      pick_ff       <= pick_in;
      pick_size_ff  <= pick_size_in;
      pick_start_ff <= pick_start_in;
      k_ff          <= k_in;
      cur_start_ff  <= cur_start_in;
      cur_size_ff   <= cur_size_in;
      status_ff     <= status_in;
      bstart_ff     <= bstart_in;
      bsize_ff      <= bsize_in;
   end

   // Drive the response payload
   assign rsp_status      = status_ff;
   assign rsp_block_start = bstart_ff;
   assign rsp_block_size  = bsize_ff;
   assign rsp_free_count  = OUT_CNT_WIDTH'(free_ff);
   assign rsp_entry_total = OUT_CNT_WIDTH'(cnt_ff);

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_WIDTH'(TABLE_DEPTH))
      else $error("entry count exceeds table depth");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= cnt_ff)
      else $error("free count exceeds entry count");

   a_split_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_ALLOC_FINISH && found_ff && pick_size_ff != size_req_ff && !full)
      |=> cnt_ff == $past(cnt_ff) + CNT_WIDTH'(1))
      else $error("split did not insert a remainder entry");
`endif

endmodule

[rtl/vpa_ctrl.sv]
// ----------------------------------------------------------------------------
// vpa_ctrl: allocator controller
// Sequences decode, table scans and merges, and runs both channel
// handshakes. Issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module vpa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  vpa_pkg::dp_status_type sts,
   output vpa_pkg::dp_cmd_type    cmd
);
   import vpa_pkg::*;

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = CMD_NONE;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd      = CMD_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (sts.opcode)
               OP_ADD: begin
                  cmd      = CMD_ADD;
                  state_in = S_RESP;
               end
               OP_BEST_FIT, OP_WORST_FIT: begin
                  if (sts.size_zero) begin
                     cmd      = CMD_NO_FIT;
                     state_in = S_RESP;
                  end else begin
                     state_in = S_FIT_SCAN;
                  end
               end
               OP_FREE: begin
                  state_in = S_FIND_SCAN;
               end
            endcase
         end
         S_FIT_SCAN: begin
            if (sts.scan_end) begin
               cmd      = CMD_ALLOC_FINISH;
               state_in = S_RESP;
            end else begin
               cmd = CMD_FIT_STEP;
            end
         end
         S_FIND_SCAN: begin
            // stop at the first entry whose start matches
            priority if (sts.scan_end) begin
               cmd      = CMD_NOT_FOUND;
               state_in = S_RESP;
            end else if (sts.rd_hit && sts.rd_used) begin
               cmd      = CMD_FREE_MARK;
               state_in = S_FREE_NEXT;
            end else if (sts.rd_hit) begin
               cmd      = CMD_NOT_FOUND;
               state_in = S_RESP;
            end else begin
               cmd = CMD_FIND_STEP;
            end
         end
         S_FREE_NEXT: begin
            cmd      = CMD_MERGE_NEXT;
            state_in = S_FREE_PREV;
         end
         S_FREE_PREV: begin
            cmd      = CMD_MERGE_PREV;
            state_in = S_RESP;
         end
         S_RESP: begin
            // hold the result; take the next transaction as it drains
            rsp_valid = 1'b1;
            req_ready = rsp_ready;
            if (rsp_ready) begin
               if (req_valid) begin
                  cmd      = CMD_LOAD;
                  state_in = S_DECODE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
      endcase
   end

`ifndef ASSERT_OFF
   a_busy_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECODE || state_ff == S_FIT_SCAN || state_ff == S_FIND_SCAN ||
       state_ff == S_FREE_NEXT || state_ff == S_FREE_PREV) |-> !req_ready)
      else $error("request taken during table work");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == S_DECODE || $past(state_ff) == S_FIT_SCAN ||
                            $past(state_ff) == S_FIND_SCAN || $past(state_ff) == S_FREE_PREV))
      else $error("response raised without a finishing step");

   a_load_on_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> cmd == CMD_LOAD)
      else $error("accepted request not latched");
`endif

endmodule
